FILE: hw/rtl/imwf_pkg.sv
// shared types and constants for the interrupt message write filter
`default_nettype none

package imwf_pkg;

  localparam int unsigned ADDR_W  = 20;
  localparam int unsigned DATA_W  = 11;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned FIELD_W = 8;
  localparam int unsigned CNT_W   = 32;

  // legal vectors: zero, the nmi vector and everything from the first free one up
  localparam logic [FIELD_W-1:0] VEC_ZERO     = 8'd0;
  localparam logic [FIELD_W-1:0] VEC_NMI      = 8'd2;
  localparam logic [FIELD_W-1:0] VEC_FIRST_OK = 8'd16;

  typedef enum logic [2:0] {
    OUT_MALFORMED   = 3'd0,
    OUT_REDIRECT    = 3'd1,
    OUT_BAD_MODE    = 3'd2,
    OUT_BAD_VECTOR  = 3'd3,
    OUT_ACCEPTED    = 3'd4,
    OUT_UNAVAILABLE = 3'd5
  } outcome_e;

  typedef struct packed {
    logic [ADDR_W-1:0] address_offset;
    logic [DATA_W-1:0] message_data;
    logic              full_word_access;
    logic              target_accepts;
  } req_t;

  typedef struct packed {
    outcome_e           outcome;
    logic [FIELD_W-1:0] target_id;
    logic [FIELD_W-1:0] target_eid;
    logic [FIELD_W-1:0] interrupt_vector;
  } dec_t;

endpackage

`default_nettype wire

FILE: hw/rtl/imwf_intf.sv
// valid/ready channel interfaces for write requests and filter results
`default_nettype none

interface imwf_req_if;
  logic                         valid;
  logic                         ready;
  logic [imwf_pkg::ADDR_W-1:0]  address_offset;
  logic [imwf_pkg::DATA_W-1:0]  message_data;
  logic                         full_word_access;
  logic                         target_accepts;

  modport source (output valid, address_offset, message_data, full_word_access,
                  target_accepts, input ready);
  modport sink   (input valid, address_offset, message_data, full_word_access,
                  target_accepts, output ready);
endinterface

interface imwf_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   outcome;
  logic                         deliver;
  logic [imwf_pkg::FIELD_W-1:0] target_id;
  logic [imwf_pkg::FIELD_W-1:0] target_eid;
  logic [imwf_pkg::FIELD_W-1:0] interrupt_vector;
  logic [imwf_pkg::CNT_W-1:0]   outcome_count;
  logic [imwf_pkg::CNT_W-1:0]   total_writes;

  modport source (output valid, outcome, deliver, target_id, target_eid,
                  interrupt_vector, outcome_count, total_writes, input ready);
  modport sink   (input valid, outcome, deliver, target_id, target_eid,
                  interrupt_vector, outcome_count, total_writes, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/imwf_classify.sv
// decode of one write beat and the filter chain that picks its outcome
`default_nettype none

module imwf_classify (
  input  imwf_pkg::req_t              req_i,
  input  logic [imwf_pkg::MODE_W-1:0] int_mode_i,
  output imwf_pkg::dec_t              dec_o
);
  import imwf_pkg::*;

  logic               malformed;
  logic               redirect;
  logic [MODE_W-1:0]  mode;
  logic [FIELD_W-1:0] vec;
  logic               vec_ok;

  always_comb begin
    malformed = !req_i.full_word_access || (req_i.address_offset[2:0] != 3'd0);
    redirect  = req_i.address_offset[3];
    mode      = req_i.message_data[10:8];
    vec       = req_i.message_data[7:0];
    vec_ok    = (vec == VEC_ZERO) || (vec == VEC_NMI) || (vec >= VEC_FIRST_OK);

    dec_o.target_id        = req_i.address_offset[19:12];
    dec_o.target_eid       = req_i.address_offset[11:4];
    dec_o.interrupt_vector = vec;

    if (malformed) begin
      dec_o.outcome          = OUT_MALFORMED;
      dec_o.target_id        = '0;
      dec_o.target_eid       = '0;
      dec_o.interrupt_vector = '0;
    end else if (redirect) begin
      dec_o.outcome = OUT_REDIRECT;
    end else if (mode != int_mode_i) begin
      dec_o.outcome = OUT_BAD_MODE;
    end else if (!vec_ok) begin
      dec_o.outcome = OUT_BAD_VECTOR;
    end else if (req_i.target_accepts) begin
      dec_o.outcome = OUT_ACCEPTED;
    end else begin
      dec_o.outcome = OUT_UNAVAILABLE;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/imwf_stats.sv
// wrapping statistics counters, one per outcome except malformed plus the all-writes count
`default_nettype none

module imwf_stats (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       bump_i,
  input  imwf_pkg::outcome_e         outcome_i,
  output logic [imwf_pkg::CNT_W-1:0] outcome_count_o,
  output logic [imwf_pkg::CNT_W-1:0] total_writes_o
);
  import imwf_pkg::*;

  logic [CNT_W-1:0] total_q, total_d;
  logic [CNT_W-1:0] redir_q, bad_mode_q, bad_vec_q, accepted_q, unavail_q;
  logic [CNT_W-1:0] sel_d;

  always_comb begin
    total_d = total_q + 1'b1;
    case (outcome_i)
      OUT_REDIRECT:    sel_d = redir_q + 1'b1;
      OUT_BAD_MODE:    sel_d = bad_mode_q + 1'b1;
      OUT_BAD_VECTOR:  sel_d = bad_vec_q + 1'b1;
      OUT_ACCEPTED:    sel_d = accepted_q + 1'b1;
      OUT_UNAVAILABLE: sel_d = unavail_q + 1'b1;
      default:         sel_d = '0;
    endcase
  end

  assign outcome_count_o = sel_d;
  assign total_writes_o  = total_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= '0;
      redir_q    <= '0;
      bad_mode_q <= '0;
      bad_vec_q  <= '0;
      accepted_q <= '0;
      unavail_q  <= '0;
    end else if (bump_i) begin
      total_q <= total_d;
      case (outcome_i)
        OUT_REDIRECT:    redir_q    <= sel_d;
        OUT_BAD_MODE:    bad_mode_q <= sel_d;
        OUT_BAD_VECTOR:  bad_vec_q  <= sel_d;
        OUT_ACCEPTED:    accepted_q <= sel_d;
        OUT_UNAVAILABLE: unavail_q  <= sel_d;
        default:         ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/interrupt_message_write_filter_unit.sv
// top level of the interrupt message write filter
`default_nettype none

// Filters writes to the interrupt delivery window. Each accepted write beat
// yields exactly one result beat: an outcome code (malformed, redirect
// ignored, mode unsupported, bad vector, accepted, unavailable), the decoded
// target ID, EID and vector, a delivery request flag and the new values of
// the matching statistics counter and of the all-writes counter; all
// counters are 32 bits and wrap. The block is a two-register pipeline: the
// write is captured in an input register, then decode, filtering and the
// counter increment happen combinationally into the result register. A new
// write is taken every cycle while the result side does not stall. A result
// is presented from the result register once its write has left the input
// register. A result that waits holds the input register, so a stall on the
// result side stops the input after one more beat. The INT delivery mode
// code is written through cfg_we_i / cfg_wdata_i and resets to zero; the
// user must write it only while no write is in flight, as the block does
// not enforce this.
module interrupt_message_write_filter_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [imwf_pkg::MODE_W-1:0] cfg_wdata_i,
  imwf_req_if.sink                    req_i,
  imwf_rsp_if.source                  rsp_o
);
  import imwf_pkg::*;

  logic [MODE_W-1:0] int_mode_q;

  logic s1_valid_q;
  req_t s1_req_q;
  req_t in_req;

  logic s2_valid_q;
  dec_t s2_dec_q;
  logic [CNT_W-1:0] s2_count_q;
  logic [CNT_W-1:0] s2_total_q;

  logic s2_free;
  logic s1_free;
  logic s1_move;

  dec_t dec;
  logic [CNT_W-1:0] count_d;
  logic [CNT_W-1:0] total_d;

  assign s2_free = !s2_valid_q || rsp_o.ready;
  assign s1_move = s1_valid_q && s2_free;
  assign s1_free = !s1_valid_q || s2_free;

  assign req_i.ready = s1_free;

  always_comb begin
    in_req.address_offset   = req_i.address_offset;
    in_req.message_data     = req_i.message_data;
    in_req.full_word_access = req_i.full_word_access;
    in_req.target_accepts   = req_i.target_accepts;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_mode_q <= '0;
    end else if (cfg_we_i) begin
      int_mode_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && req_i.valid) begin
      s1_req_q <= in_req;
    end
  end

  imwf_classify u_classify (
    .req_i      (s1_req_q),
    .int_mode_i (int_mode_q),
    .dec_o      (dec)
  );

  imwf_stats u_stats (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .bump_i          (s1_move),
    .outcome_i       (dec.outcome),
    .outcome_count_o (count_d),
    .total_writes_o  (total_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_free) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      s2_dec_q   <= dec;
      s2_count_q <= count_d;
      s2_total_q <= total_d;
    end
  end

  assign rsp_o.valid            = s2_valid_q;
  assign rsp_o.outcome          = s2_dec_q.outcome;
  assign rsp_o.deliver          = (s2_dec_q.outcome == OUT_ACCEPTED) ||
                                  (s2_dec_q.outcome == OUT_UNAVAILABLE);
  assign rsp_o.target_id        = s2_dec_q.target_id;
  assign rsp_o.target_eid       = s2_dec_q.target_eid;
  assign rsp_o.interrupt_vector = s2_dec_q.interrupt_vector;
  assign rsp_o.outcome_count    = s2_count_q;
  assign rsp_o.total_writes     = s2_total_q;

endmodule

`default_nettype wire

FILE: tb/sv/imwf_result_checker.sv
// checker that predicts and compares interrupt write filter results
`timescale 1ns / 100ps

module imwf_result_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [imwf_pkg::MODE_W-1:0] cfg_wdata_i,
  imwf_req_if                         req_i,
  imwf_rsp_if                         rsp_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o
);
  import imwf_pkg::*;

  typedef struct packed {
    outcome_e           outcome;
    logic               deliver;
    logic [FIELD_W-1:0] target_id;
    logic [FIELD_W-1:0] target_eid;
    logic [FIELD_W-1:0] interrupt_vector;
    logic [CNT_W-1:0]   outcome_count;
    logic [CNT_W-1:0]   total_writes;
  } filter_result_t;

  filter_result_t     expected_results[$];
  logic [MODE_W-1:0]  int_mode;
  logic [CNT_W-1:0]   total_writes;
  // one counter per outcome code, the malformed slot stays unused
  logic [CNT_W-1:0]   outcome_counts[OUT_UNAVAILABLE+1];

  function automatic filter_result_t predict_write(input logic [ADDR_W-1:0] addr,
                                                   input logic [DATA_W-1:0] data,
                                                   input logic full,
                                                   input logic accepts);
    filter_result_t r;
    logic [FIELD_W-1:0] vec;
    logic [MODE_W-1:0]  mode;
    r = '0;
    total_writes = total_writes + 1;
    r.total_writes = total_writes;
    r.outcome = OUT_MALFORMED;
    if (full && addr[2:0] == 3'b000) begin
      vec  = data[7:0];
      mode = data[10:8];
      r.target_id        = addr[19:12];
      r.target_eid       = addr[11:4];
      r.interrupt_vector = vec;
      if (addr[3]) begin
        r.outcome = OUT_REDIRECT;
      end else if (mode != int_mode) begin
        r.outcome = OUT_BAD_MODE;
      end else if (!(vec == VEC_ZERO || vec == VEC_NMI || vec >= VEC_FIRST_OK)) begin
        r.outcome = OUT_BAD_VECTOR;
      end else if (accepts) begin
        r.outcome = OUT_ACCEPTED;
      end else begin
        r.outcome = OUT_UNAVAILABLE;
      end
      r.deliver = (r.outcome == OUT_ACCEPTED || r.outcome == OUT_UNAVAILABLE);
      outcome_counts[r.outcome] = outcome_counts[r.outcome] + 1;
      r.outcome_count = outcome_counts[r.outcome];
    end
    return r;
  endfunction

  task automatic note_failure(input string msg);
    if (fail_count_o < 10) begin
      $display("%0t: %s", $realtime, msg);
    end
    fail_count_o = fail_count_o + 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    filter_result_t seen;
    filter_result_t want;
    if (!rst_ni) begin
      expected_results.delete();
      int_mode     = '0;
      total_writes = '0;
      foreach (outcome_counts[i]) outcome_counts[i] = '0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // compare first: a result never belongs to a write taken at the same edge
      if (rsp_i.valid && rsp_i.ready) begin
        seen.outcome          = outcome_e'(rsp_i.outcome);
        seen.deliver          = rsp_i.deliver;
        seen.target_id        = rsp_i.target_id;
        seen.target_eid       = rsp_i.target_eid;
        seen.interrupt_vector = rsp_i.interrupt_vector;
        seen.outcome_count    = rsp_i.outcome_count;
        seen.total_writes     = rsp_i.total_writes;
        if (expected_results.size() == 0) begin
          note_failure($sformatf("result beat with nothing expected: %p", seen));
        end else begin
          want = expected_results.pop_front();
          if (seen.outcome !== want.outcome || seen.deliver !== want.deliver ||
              seen.target_id !== want.target_id || seen.target_eid !== want.target_eid ||
              seen.interrupt_vector !== want.interrupt_vector ||
              seen.outcome_count !== want.outcome_count ||
              seen.total_writes !== want.total_writes) begin
            note_failure($sformatf("result mismatch\n  expected %p\n  actual   %p",
                                   want, seen));
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        expected_results.push_back(predict_write(req_i.address_offset, req_i.message_data,
                                                 req_i.full_word_access,
                                                 req_i.target_accepts));
      end
      if (cfg_we_i) begin
        int_mode = cfg_wdata_i;
      end
      pending_o = expected_results.size();
    end
  end

endmodule

FILE: tb/sv/interrupt_message_write_filter_unit_tb.sv
// testbench top: stimulus, config phases and verdict for the write filter
`timescale 1ns / 100ps

module interrupt_message_write_filter_unit_tb;
  import imwf_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [MODE_W-1:0] cfg_wdata_i;
  int unsigned       fail_count;
  int unsigned       pending_writes;
  logic              idle_en;
  logic [MODE_W-1:0] mode_now;

  imwf_req_if req_if ();
  imwf_rsp_if rsp_if ();

  interrupt_message_write_filter_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  imwf_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending_writes)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #2400000;
    $display("FAIL interrupt_message_write_filter_unit");
    $finish;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic [ADDR_W-1:0] win_addr(input logic [7:0] id, input logic [7:0] eid,
                                                 input logic redir, input logic [2:0] low);
    return {id, eid, redir, low};
  endfunction

  // result side back-pressure
  initial begin : result_stall
    int unsigned stall_left;
    stall_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        rsp_if.ready <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        rsp_if.ready <= 1'b1;
        if (idle_en && $urandom_range(0, 3) == 0) begin
          stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                    : $urandom_range(4, 20);
        end
      end
    end
  end

  task automatic send_write(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d,
                            input logic f, input logic t);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid            <= 1'b1;
    req_if.address_offset   <= a;
    req_if.message_data     <= d;
    req_if.full_word_access <= f;
    req_if.target_accepts   <= t;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending_writes != 0);
    @(posedge clk_i);
  endtask

  task automatic set_int_mode(input logic [MODE_W-1:0] m);
    wait_drained();
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mode_now = m;
  endtask

  initial begin : stimulus
    logic [ADDR_W-1:0] a;
    logic [DATA_W-1:0] d;
    logic              f;
    logic [MODE_W-1:0] phase_modes[5];
    int unsigned       kind;

    rst_ni                  <= 1'b0;
    cfg_we_i                <= 1'b0;
    cfg_wdata_i             <= '0;
    req_if.valid            <= 1'b0;
    req_if.address_offset   <= '0;
    req_if.message_data     <= '0;
    req_if.full_word_access <= 1'b0;
    req_if.target_accepts   <= 1'b0;
    idle_en  = 1'b1;
    mode_now = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part, INT mode code at its reset value
    send_write(win_addr(8'h00, 8'h00, 1'b0, 3'b000), {3'd0, 8'd0}, 1'b0, 1'b1);
    send_write(win_addr(8'hff, 8'hff, 1'b0, 3'b001), {3'd0, 8'd16}, 1'b1, 1'b1);
    send_write(win_addr(8'h12, 8'h34, 1'b0, 3'b010), {3'd0, 8'd16}, 1'b1, 1'b1);
    send_write(win_addr(8'h12, 8'h34, 1'b1, 3'b100), {3'd0, 8'd16}, 1'b1, 1'b1);
    send_write(win_addr(8'hff, 8'hff, 1'b1, 3'b111), {3'd7, 8'hff}, 1'b0, 1'b0);
    // redirect wins over everything behind it
    send_write(win_addr(8'hff, 8'hff, 1'b1, 3'b000), {3'd7, 8'hff}, 1'b1, 1'b1);
    send_write(win_addr(8'h01, 8'h80, 1'b1, 3'b000), {3'd0, 8'd1}, 1'b1, 1'b0);
    // mode check comes before the vector check
    send_write(win_addr(8'h80, 8'h01, 1'b0, 3'b000), {3'd7, 8'd16}, 1'b1, 1'b1);
    send_write(win_addr(8'h55, 8'haa, 1'b0, 3'b000), {3'd4, 8'd1}, 1'b1, 1'b1);
    send_write(win_addr(8'haa, 8'h55, 1'b0, 3'b000), {3'd0, 8'd1}, 1'b1, 1'b1);
    send_write(win_addr(8'h0f, 8'hf0, 1'b0, 3'b000), {3'd0, 8'd3}, 1'b1, 1'b0);
    send_write(win_addr(8'hf0, 8'h0f, 1'b0, 3'b000), {3'd0, 8'd15}, 1'b1, 1'b1);
    // legal vectors, target taking and not taking the interrupt
    send_write(win_addr(8'h00, 8'h00, 1'b0, 3'b000), {3'd0, 8'd0}, 1'b1, 1'b1);
    send_write(win_addr(8'h00, 8'h00, 1'b0, 3'b000), {3'd0, 8'd0}, 1'b1, 1'b0);
    send_write(win_addr(8'h3c, 8'hc3, 1'b0, 3'b000), {3'd0, 8'd2}, 1'b1, 1'b1);
    send_write(win_addr(8'hc3, 8'h3c, 1'b0, 3'b000), {3'd0, 8'd16}, 1'b1, 1'b0);
    send_write(win_addr(8'hff, 8'hff, 1'b0, 3'b000), {3'd0, 8'hff}, 1'b1, 1'b1);
    send_write(win_addr(8'hff, 8'hff, 1'b0, 3'b000), {3'd0, 8'hff}, 1'b1, 1'b0);

    phase_modes[0] = 3'd7;
    phase_modes[1] = 3'd3;
    phase_modes[2] = 3'd0;
    phase_modes[3] = 3'($urandom_range(0, 7));
    phase_modes[4] = 3'd5;
    foreach (phase_modes[p]) begin
      set_int_mode(phase_modes[p]);
      for (int i = 0; i < 100; i++) begin
        // stretches of twenty beats with no idling on either side
        idle_en = ((i + 20 * p) % 80) >= 20;
        if ((p == 0 && i == 50) || $urandom_range(0, 99) == 0) begin
          wait_drained();
        end
        kind = $urandom_range(0, 99);
        a = 20'($urandom_range(0, 20'hfffff));
        d = 11'($urandom_range(0, 11'h7ff));
        f = 1'b1;
        if (kind < 12) begin
          if ($urandom_range(0, 1) == 0) f = 1'b0;
          else a[2:0] = 3'($urandom_range(1, 7));
        end else begin
          a[2:0] = 3'b000;
          a[3]   = ($urandom_range(0, 4) == 0);
          if ($urandom_range(0, 3) != 0) d[10:8] = mode_now;
          if ($urandom_range(0, 9) < 3) d[7:0] = 8'($urandom_range(0, 20));
        end
        send_write(a, d, f, 1'($urandom_range(0, 1)));
      end
    end

    idle_en = 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending_writes == 0) begin
      $display("PASS interrupt_message_write_filter_unit");
    end else begin
      $display("FAIL interrupt_message_write_filter_unit");
    end
    $finish;
  end

endmodule
